>>> sv/tpar_pkg.sv
// ----------------------------------------------------------------------------
// tpar_pkg
// Shared constants and codes for the TLB paging unit with aging replacement.
// ----------------------------------------------------------------------------
package tpar_pkg;

  // Default geometry
  localparam int DEF_PAGE_BITS  = 16;
  localparam int DEF_MAX_FRAMES = 256;
  localparam int DEF_MAX_TLB    = 16;
  localparam int DEF_USE_BITS   = 8;

  // Fixed field widths
  localparam int VA_W     = 24;
  localparam int OFF_W    = 8;
  localparam int PA_W     = 16;
  localparam int PFN_OUT_W = 8;
  localparam int SLOT_W   = 4;
  localparam int EVICT_W  = 16;
  localparam int CNT32_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAMES_W = 9;
  localparam int TLBN_W   = 5;
  localparam int PERIOD_W = 16;

  // Register reset values
  localparam logic [FRAMES_W-1:0] FRAMES_RST = 9'd8;
  localparam logic [TLBN_W-1:0]   TLBN_RST   = 5'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TLBN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

  // Outcome codes
  localparam logic [1:0] OUT_TLB_HIT  = 2'd0;
  localparam logic [1:0] OUT_PAGE_HIT = 2'd1;
  localparam logic [1:0] OUT_FREE     = 2'd2;
  localparam logic [1:0] OUT_REPLACE  = 2'd3;

endpackage

>>> sv/tlb_paging_aging_replacement_unit.sv
// ----------------------------------------------------------------------------
// tlb_paging_aging_replacement_unit
// Translates one virtual address per request through a fully associative TLB,
// a page table and a core map with aging pseudo-LRU frame replacement.
// ----------------------------------------------------------------------------
// After reset the page table is cleared one entry per cycle, all 2**PAGE_BITS
// entries, with busy high. A request is taken when start is high and busy low;
// the result appears for exactly one cycle with done and cannot be held off.
// A sequencer runs one shared compare unit over the TLB entries (nt entries in
// use), and the core map RAM is swept one frame per cycle (nf frames in use)
// for the free/victim search and again for use-vector aging.
// ----------------------------------------------------------------------------
module tlb_paging_aging_replacement_unit
  import tpar_pkg::*;
#(
  parameter int PAGE_BITS  = DEF_PAGE_BITS,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int MAX_TLB    = DEF_MAX_TLB,
  parameter int USE_BITS   = DEF_USE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VA_W-1:0]       virt_addr,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [PA_W-1:0]       phys_addr,
  output logic [1:0]            outcome,
  output logic [SLOT_W-1:0]     tlb_slot,
  output logic [EVICT_W-1:0]    evicted_page,
  output logic [CNT32_W-1:0]    access_total,
  output logic [CNT32_W-1:0]    miss_total,
  output logic [CNT32_W-1:0]    fault_total
);

  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int TLB_W   = (MAX_TLB > 1) ? $clog2(MAX_TLB) : 1;
  localparam int CNT_W   = PAGE_BITS + 1;
  localparam int PAGE_COUNT = 1 << PAGE_BITS;
  localparam int PT_W    = FRAME_W + 1;
  localparam int CM_W    = PAGE_BITS + USE_BITS;
  localparam logic [USE_BITS-1:0] USE_TOP = {1'b1, {(USE_BITS-1){1'b0}}};

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_TLB      = 13'b0000000000100,
    S_PT_WAIT  = 13'b0000000001000,
    S_SCAN     = 13'b0000000010000,
    S_EVICT    = 13'b0000000100000,
    S_PT_MAP   = 13'b0000001000000,
    S_REFILL   = 13'b0000010000000,
    S_TOUCH_RD = 13'b0000100000000,
    S_TOUCH_WR = 13'b0001000000000,
    S_PERIOD   = 13'b0010000000000,
    S_AGE      = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [FRAMES_W-1:0] frames_in_use;
  logic [TLBN_W-1:0]   tlb_entries_in_use;
  logic [PERIOD_W-1:0] shift_period;

  // TLB entries
  logic                 tlb_valid [MAX_TLB];
  logic [PAGE_BITS-1:0] tlb_vpn   [MAX_TLB];
  logic [FRAME_W-1:0]   tlb_pfn   [MAX_TLB];
  logic [TLB_W-1:0]     rr_ptr;

  // Core map valid bits (payload lives in RAM)
  logic [MAX_FRAMES-1:0] cm_valid;

  // Per-request registers
  logic [CNT_W-1:0]     cnt;
  logic [PAGE_BITS-1:0] vpn;
  logic [OFF_W-1:0]     offset;
  logic [FRAME_W-1:0]   pfn;
  logic [1:0]           res_outcome;
  logic [TLB_W-1:0]     slot;
  logic [PAGE_BITS-1:0] evicted;
  logic [CNT32_W-1:0]   access_counter, miss_counter, fault_counter;
  logic [PERIOD_W-1:0]  shift_countdown;

  // Scan registers
  logic                 found, any;
  logic [FRAME_W-1:0]   free_idx, best;
  logic [USE_BITS-1:0]  best_use;
  logic [PAGE_BITS-1:0] best_vpn;
  logic                 found_next, any_next;
  logic [FRAME_W-1:0]   free_idx_next, best_next;
  logic [USE_BITS-1:0]  best_use_next;
  logic [PAGE_BITS-1:0] best_vpn_next;

  // RAM ports
  logic                 pt_we;
  logic [PAGE_BITS-1:0] pt_waddr;
  logic [PT_W-1:0]      pt_wdata, pt_rdata;
  logic                 cm_we;
  logic [FRAME_W-1:0]   cm_waddr, cm_raddr;
  logic [CM_W-1:0]      cm_wdata, cm_rdata;

  // Derived limits
  logic [TLB_W:0]        nt;
  logic [FRAME_W:0]      nf;
  logic [PERIOD_W-1:0]   period;
  logic [PERIOD_W-1:0]   sc_inc;
  logic [TLB_W-1:0]      tidx;
  logic [FRAME_W-1:0]    scan_idx;
  logic                  scan_v;
  logic [USE_BITS-1:0]   rd_use, u;
  logic [PAGE_BITS-1:0]  rd_vpn, v_vpn;
  logic                  tlb_match;
  logic [TLB_W-1:0]      rr_sel;

  // Clamp configuration
  always_comb begin
    if (tlb_entries_in_use == '0) begin
      nt = (TLB_W+1)'(1);
    end else if (32'(tlb_entries_in_use) > MAX_TLB) begin
      nt = (TLB_W+1)'(MAX_TLB);
    end else begin
      nt = (TLB_W+1)'(tlb_entries_in_use);
    end
    if (frames_in_use == '0) begin
      nf = (FRAME_W+1)'(1);
    end else if (32'(frames_in_use) > MAX_FRAMES) begin
      nf = (FRAME_W+1)'(MAX_FRAMES);
    end else begin
      nf = (FRAME_W+1)'(frames_in_use);
    end
    period = (shift_period == '0) ? PERIOD_W'(1) : shift_period;
    sc_inc = shift_countdown + 1'b1;
  end

  // Shared compare unit and scan decode
  always_comb begin
    tidx      = cnt[TLB_W-1:0];
    tlb_match = tlb_valid[tidx] && (tlb_vpn[tidx] == vpn);
    rr_sel    = ((TLB_W+1)'(rr_ptr) >= nt) ? '0 : rr_ptr;
    scan_idx  = FRAME_W'(cnt - 1'b1);
    scan_v    = cm_valid[scan_idx];
    rd_use    = cm_rdata[USE_BITS-1:0];
    rd_vpn    = cm_rdata[USE_BITS +: PAGE_BITS];
    u         = scan_v ? rd_use : '0;
    v_vpn     = scan_v ? rd_vpn : '0;
  end

  // Free-frame and victim tracking for the current scan step
  always_comb begin
    found_next    = found;
    free_idx_next = free_idx;
    any_next      = any;
    best_next     = best;
    best_use_next = best_use;
    best_vpn_next = best_vpn;
    if (cnt != '0) begin
      if (!scan_v && !found) begin
        found_next    = 1'b1;
        free_idx_next = scan_idx;
      end
      if (cnt == CNT_W'(1)) begin
        best_next     = '0;
        best_vpn_next = v_vpn;
        any_next      = (u != '0);
        best_use_next = u;
      end else if (u != '0 && (!any || u < best_use)) begin
        any_next      = 1'b1;
        best_next     = scan_idx;
        best_use_next = u;
        best_vpn_next = v_vpn;
      end
    end
  end

  // Page table port control
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = vpn;
    pt_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = cnt[PAGE_BITS-1:0];
      end
      S_EVICT: begin
        pt_we    = 1'b1;
        pt_waddr = evicted;
      end
      S_PT_MAP: begin
        pt_we    = 1'b1;
        pt_wdata = {1'b1, pfn};
      end
      default: begin
      end
    endcase
  end

  // Core map port control
  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = pfn;
    cm_wdata = '0;
    cm_raddr = (state == S_TOUCH_RD) ? pfn : cnt[FRAME_W-1:0];
    unique case (state)
      S_PT_MAP: begin
        cm_we    = 1'b1;
        cm_wdata = {vpn, USE_TOP};
      end
      S_TOUCH_WR: begin
        cm_we    = 1'b1;
        cm_wdata = {rd_vpn, rd_use | USE_TOP};
      end
      S_AGE: begin
        cm_we    = (cnt != '0) && scan_v;
        cm_waddr = scan_idx;
        cm_wdata = {rd_vpn, rd_use >> 1};
      end
      default: begin
      end
    endcase
  end

  tpar_ram #(.WIDTH(PT_W), .DEPTH(PAGE_COUNT)) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (vpn),
    .rdata (pt_rdata)
  );

  tpar_ram #(.WIDTH(CM_W), .DEPTH(MAX_FRAMES)) u_core_map (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use      <= FRAMES_RST;
      tlb_entries_in_use <= TLBN_RST;
      shift_period       <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAMES: frames_in_use      <= cfg_data[FRAMES_W-1:0];
        CFG_TLBN:   tlb_entries_in_use <= cfg_data[TLBN_W-1:0];
        CFG_PERIOD: shift_period       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      cnt             <= '0;
      rr_ptr          <= '0;
      cm_valid        <= '0;
      access_counter  <= '0;
      miss_counter    <= '0;
      fault_counter   <= '0;
      shift_countdown <= '0;
      for (int i = 0; i < MAX_TLB; i++) begin
        tlb_valid[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        // Sweep the page table to not-present
        S_CLEAR: begin
          if (cnt == CNT_W'(PAGE_COUNT - 1)) begin
            state <= S_IDLE;
          end
          cnt <= cnt + 1'b1;
        end
        // Take a request
        S_IDLE: begin
          if (start) begin
            vpn         <= virt_addr[OFF_W +: PAGE_BITS];
            offset      <= virt_addr[OFF_W-1:0];
            slot        <= '0;
            evicted     <= '0;
            cnt         <= '0;
            if (access_counter != '1) begin
              access_counter <= access_counter + 1'b1;
            end
            state <= S_TLB;
          end
        end
        // Search the TLB one entry per cycle
        S_TLB: begin
          if (tlb_match) begin
            pfn         <= tlb_pfn[tidx];
            res_outcome <= OUT_TLB_HIT;
            state       <= S_TOUCH_RD;
          end else if (cnt + 1'b1 == CNT_W'(nt)) begin
            if (miss_counter != '1) begin
              miss_counter <= miss_counter + 1'b1;
            end
            state <= S_PT_WAIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        // Check the page table
        S_PT_WAIT: begin
          cnt <= '0;
          if (pt_rdata[PT_W-1]) begin
            pfn         <= pt_rdata[FRAME_W-1:0];
            res_outcome <= OUT_PAGE_HIT;
            state       <= S_REFILL;
          end else begin
            if (fault_counter != '1) begin
              fault_counter <= fault_counter + 1'b1;
            end
            found <= 1'b0;
            any   <= 1'b0;
            state <= S_SCAN;
          end
        end
        // Sweep the core map for a free frame and the aging victim
        S_SCAN: begin
          found    <= found_next;
          free_idx <= free_idx_next;
          any      <= any_next;
          best     <= best_next;
          best_use <= best_use_next;
          best_vpn <= best_vpn_next;
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(nf)) begin
            if (found_next) begin
              res_outcome <= OUT_FREE;
              pfn         <= free_idx_next;
              state       <= S_PT_MAP;
            end else begin
              res_outcome <= OUT_REPLACE;
              pfn         <= best_next;
              evicted     <= best_vpn_next;
              state       <= S_EVICT;
            end
          end
        end
        // Drop the victim page from every TLB entry
        S_EVICT: begin
          for (int i = 0; i < MAX_TLB; i++) begin
            if (tlb_vpn[i] == evicted) begin
              tlb_valid[i] <= 1'b0;
            end
          end
          state <= S_PT_MAP;
        end
        // Map the faulting page to its frame
        S_PT_MAP: begin
          cm_valid[pfn] <= 1'b1;
          cnt           <= '0;
          state         <= S_REFILL;
        end
        // Refill the first invalid slot, else the round-robin slot
        S_REFILL: begin
          if (!tlb_valid[tidx]) begin
            tlb_valid[tidx] <= 1'b1;
            tlb_vpn[tidx]   <= vpn;
            tlb_pfn[tidx]   <= pfn;
            slot            <= tidx;
            state <= (res_outcome == OUT_PAGE_HIT) ? S_TOUCH_RD : S_PERIOD;
          end else if (cnt + 1'b1 == CNT_W'(nt)) begin
            tlb_valid[rr_sel] <= 1'b1;
            tlb_vpn[rr_sel]   <= vpn;
            tlb_pfn[rr_sel]   <= pfn;
            slot              <= rr_sel;
            rr_ptr <= ((TLB_W+1)'(rr_sel) + 1'b1 == nt) ? '0 : rr_sel + 1'b1;
            state <= (res_outcome == OUT_PAGE_HIT) ? S_TOUCH_RD : S_PERIOD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        // Read-modify-write the touched frame's use vector
        S_TOUCH_RD: begin
          state <= S_TOUCH_WR;
        end
        S_TOUCH_WR: begin
          state <= S_PERIOD;
        end
        // Advance the aging period
        S_PERIOD: begin
          cnt <= '0;
          if (sc_inc >= period) begin
            shift_countdown <= '0;
            state           <= S_AGE;
          end else begin
            shift_countdown <= sc_inc;
            state           <= S_DONE;
          end
        end
        // Shift the valid frames' use vectors right, one frame per cycle
        S_AGE: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(nf)) begin
            state <= S_DONE;
          end
        end
        // Present the result
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Outputs
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign phys_addr    = {PFN_OUT_W'(pfn), offset};
  assign outcome      = res_outcome;
  assign tlb_slot     = SLOT_W'(slot);
  assign evicted_page = EVICT_W'(evicted);
  assign access_total = access_counter;
  assign miss_total   = miss_counter;
  assign fault_total  = fault_counter;

endmodule

>>> sv/tpar_ram.sv
// ----------------------------------------------------------------------------
// tpar_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
